// ===== rtl/rcss_pkg.sv =====
package rcss_pkg;

  // Table geometry and limits
  localparam int unsigned SEQ_DEPTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(SEQ_DEPTH);
  localparam int unsigned MAX_CHIPS = 64;
  localparam int unsigned CNT_W     = $clog2(MAX_CHIPS);

  // Sample and chip formats
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CHIP_W    = 16;
  localparam int unsigned CHIP_FRAC = 12;
  localparam int unsigned PROD_W    = SAMPLE_W + CHIP_W;

  // Configuration registers
  localparam int unsigned CPS_W     = 7;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 11;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SPREAD = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHIPS   = 2'd0,
    REG_SEQ_LEN = 2'd1
  } cfg_reg_e;

  // Table write from a load word
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [CHIP_W-1:0] data;
  } load_t;

  // One chip issued into the datapath
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic signed [SAMPLE_W-1:0] sym_i;
    logic signed [SAMPLE_W-1:0] sym_q;
  } issue_t;

endpackage

// ===== rtl/rcss_in_if.sv =====
interface rcss_in_if;
  logic                                 valid;
  logic                                 ready;
  rcss_pkg::cmd_e                       command;
  logic [rcss_pkg::ADDR_W-1:0]          chip_addr;
  logic signed [rcss_pkg::CHIP_W-1:0]   chip_value;
  logic signed [rcss_pkg::SAMPLE_W-1:0] symbol_i;
  logic signed [rcss_pkg::SAMPLE_W-1:0] symbol_q;

  modport source (
    output valid, command, chip_addr, chip_value, symbol_i, symbol_q,
    input  ready
  );
  modport sink (
    input  valid, command, chip_addr, chip_value, symbol_i, symbol_q,
    output ready
  );
endinterface

// ===== rtl/rcss_out_if.sv =====
interface rcss_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rcss_pkg::SAMPLE_W-1:0] out_i;
  logic signed [rcss_pkg::SAMPLE_W-1:0] out_q;
  logic                                 last_chip;

  modport source (
    output valid, out_i, out_q, last_chip,
    input  ready
  );
  modport sink (
    input  valid, out_i, out_q, last_chip,
    output ready
  );
endinterface

// ===== rtl/real_chip_sequence_spreader.sv =====
// Channel   Dir  Payload                                          Accepted when
// item_i    in   command, chip_addr, chip_value, symbol_i/_q      valid && ready
// result_o  out  out_i, out_q, last_chip                          valid && ready
// cfg       in   cfg_we_i, cfg_index_i, cfg_data_i                cfg_we_i high
//
// One result word per cycle while result_o is ready; a symbol word yields one word
// per configured chip, and the next symbol is taken as the current one's final chip issues.
// The first result word of a symbol passes stage 1, stage 2 and the output register.
// Loads give no result. A sequence length write blocks item_i while the chip
// position is reduced modulo the new length.
// Reset clears control state only (table undefined until loaded); a stalled
// result_o holds the whole datapath and the chip sequencer.
module real_chip_sequence_spreader (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcss_pkg::CFG_W-1:0]     cfg_data_i,
  rcss_in_if.sink                        item_i,
  rcss_out_if.source                     result_o
);
  import rcss_pkg::*;

  load_t                    load;
  issue_t                   issue;
  logic [ADDR_W-1:0]        raddr;
  logic signed [CHIP_W-1:0] chip;
  logic                     adv;

  rcss_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .adv_i       (adv),
    .load_o      (load),
    .raddr_o     (raddr),
    .issue_o     (issue)
  );

  rcss_chip_store u_chip_store (
    .clk_i   (clk_i),
    .load_i  (load),
    .re_i    (adv),
    .raddr_i (raddr),
    .rdata_o (chip)
  );

  rcss_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .chip_i   (chip),
    .adv_o    (adv),
    .result_o (result_o)
  );

endmodule

// ===== rtl/rcss_chip_store.sv =====
module rcss_chip_store (
  input  logic                               clk_i,
  input  rcss_pkg::load_t                    load_i,
  input  logic                               re_i,
  input  logic [rcss_pkg::ADDR_W-1:0]        raddr_i,
  output logic signed [rcss_pkg::CHIP_W-1:0] rdata_o
);
  import rcss_pkg::*;

  logic signed [CHIP_W-1:0] mem [SEQ_DEPTH];
  logic signed [CHIP_W-1:0] rdata_q;

  // Write a loaded chip
  always_ff @(posedge clk_i) begin
    if (load_i.we) begin
      mem[load_i.addr] <= load_i.data;
    end
  end

  // Read one chip per advancing cycle, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rcss_sequencer.sv =====
module rcss_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcss_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rcss_pkg::CFG_W-1:0]           cfg_data_i,
  rcss_in_if.sink                              item_i,
  input  logic                                 adv_i,
  output rcss_pkg::load_t                      load_o,
  output logic [rcss_pkg::ADDR_W-1:0]          raddr_o,
  output rcss_pkg::issue_t                     issue_o
);
  import rcss_pkg::*;

  localparam int unsigned RCNT_W = $clog2(ADDR_W + 1);

  logic [CPS_W-1:0]          cps_q, cps_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [ADDR_W-1:0]         pos_q, pos_d;
  logic                      busy_q, busy_d;
  logic [CNT_W-1:0]          left_q, left_d;
  logic signed [SAMPLE_W-1:0] sym_i_q, sym_i_d;
  logic signed [SAMPLE_W-1:0] sym_q_q, sym_q_d;
  logic                      red_busy_q, red_busy_d;
  logic [RCNT_W-1:0]         red_cnt_q, red_cnt_d;
  logic [ADDR_W-1:0]         red_src_q, red_src_d;
  logic [ADDR_W-1:0]         rem_q, rem_d;

  logic [CPS_W-1:0]  cps_eff;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] len_last;
  logic [ADDR_W-1:0] pos_step;
  logic [LEN_W-1:0]  rem_sh;
  logic [LEN_W-1:0]  rem_sub;
  logic [ADDR_W-1:0] rem_n;
  logic              accept;
  logic              issue_fire;
  logic              len_write;

  // Clamp register values into their working ranges
  always_comb begin
    if (cps_q == '0) begin
      cps_eff = CPS_W'(1);
    end else if (cps_q > CPS_W'(MAX_CHIPS)) begin
      cps_eff = CPS_W'(MAX_CHIPS);
    end else begin
      cps_eff = cps_q;
    end
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(SEQ_DEPTH)) begin
      len_eff = LEN_W'(SEQ_DEPTH);
    end else begin
      len_eff = len_q;
    end
  end

  assign len_last = ADDR_W'(len_eff - LEN_W'(1));
  assign pos_step = (pos_q == len_last) ? '0 : pos_q + ADDR_W'(1);

  // One restoring remainder step: position mod sequence length
  assign rem_sh  = {rem_q, red_src_q[ADDR_W-1]};
  assign rem_sub = rem_sh - len_eff;
  assign rem_n   = (rem_sh >= len_eff) ? rem_sub[ADDR_W-1:0] : rem_sh[ADDR_W-1:0];

  // Take a word unless reducing: when idle or issuing a final chip
  assign item_i.ready = !red_busy_q && (!busy_q || (adv_i && left_q == '0));
  assign accept       = item_i.valid && item_i.ready;
  assign issue_fire   = adv_i && busy_q;
  assign len_write    = cfg_we_i && (cfg_index_i == REG_SEQ_LEN);

  always_comb begin
    cps_d      = cps_q;
    len_d      = len_q;
    pos_d      = pos_q;
    busy_d     = busy_q;
    left_d     = left_q;
    sym_i_d    = sym_i_q;
    sym_q_d    = sym_q_q;
    red_busy_d = red_busy_q;
    red_cnt_d  = red_cnt_q;
    red_src_d  = red_src_q;
    rem_d      = rem_q;

    // Register writes
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CHIPS:   cps_d = cfg_data_i[CPS_W-1:0];
        REG_SEQ_LEN: len_d = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end

    // Reduce the position after a length change, one bit per cycle
    if (len_write) begin
      red_busy_d = 1'b1;
      red_cnt_d  = RCNT_W'(ADDR_W);
      red_src_d  = pos_q;
      rem_d      = '0;
    end else if (red_busy_q) begin
      red_src_d = red_src_q << 1;
      rem_d     = rem_n;
      red_cnt_d = red_cnt_q - RCNT_W'(1);
      if (red_cnt_q == RCNT_W'(1)) begin
        red_busy_d = 1'b0;
        pos_d      = rem_n;
      end
    end

    // Advance through the chips of the current symbol
    if (issue_fire) begin
      pos_d = pos_step;
      if (left_q == '0) begin
        busy_d = 1'b0;
      end else begin
        left_d = left_q - CNT_W'(1);
      end
    end

    // Start a symbol or restart the sequence on a load
    if (accept) begin
      if (item_i.command == CMD_LOAD) begin
        pos_d = '0;
      end else begin
        busy_d  = 1'b1;
        left_d  = CNT_W'(cps_eff - CPS_W'(1));
        sym_i_d = item_i.symbol_i;
        sym_q_d = item_i.symbol_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q      <= CPS_W'(1);
      len_q      <= LEN_W'(SEQ_DEPTH);
      pos_q      <= '0;
      busy_q     <= 1'b0;
      left_q     <= '0;
      red_busy_q <= 1'b0;
      red_cnt_q  <= '0;
    end else begin
      cps_q      <= cps_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      busy_q     <= busy_d;
      left_q     <= left_d;
      red_busy_q <= red_busy_d;
      red_cnt_q  <= red_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_i_q   <= sym_i_d;
    sym_q_q   <= sym_q_d;
    red_src_q <= red_src_d;
    rem_q     <= rem_d;
  end

  assign load_o.we   = accept && (item_i.command == CMD_LOAD);
  assign load_o.addr = item_i.chip_addr;
  assign load_o.data = item_i.chip_value;

  assign raddr_o       = pos_q;
  assign issue_o.valid = busy_q;
  assign issue_o.last  = (left_q == '0);
  assign issue_o.sym_i = sym_i_q;
  assign issue_o.sym_q = sym_q_q;

endmodule

// ===== rtl/rcss_scaler.sv =====
module rcss_scaler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rcss_pkg::issue_t                   issue_i,
  input  logic signed [rcss_pkg::CHIP_W-1:0] chip_i,
  output logic                               adv_o,
  rcss_out_if.source                         result_o
);
  import rcss_pkg::*;

  localparam int unsigned SUM_W = PROD_W + 1;
  localparam int unsigned SH_W  = SUM_W - CHIP_FRAC;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(2 ** (SAMPLE_W - 1));

  // Round half up, drop the chip fraction, saturate to sample range
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SH_W-1:0]  sh;
    logic signed [SAMPLE_W-1:0] r;
    sum = SUM_W'(p) + SUM_W'(2 ** (CHIP_FRAC - 1));
    sh  = sum[SUM_W-1:CHIP_FRAC];
    if (sh > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (sh < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = sh[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  logic                       s1_valid_q;
  logic                       s1_last_q;
  logic signed [SAMPLE_W-1:0] s1_sym_i_q;
  logic signed [SAMPLE_W-1:0] s1_sym_q_q;
  logic                       s2_valid_q;
  logic                       s2_last_q;
  logic signed [PROD_W-1:0]   s2_prod_i_q;
  logic signed [PROD_W-1:0]   s2_prod_q_q;
  logic                       out_valid_q;
  logic                       out_last_q;
  logic signed [SAMPLE_W-1:0] out_i_q;
  logic signed [SAMPLE_W-1:0] out_q_q;

  // Hold the whole pipe while a result word waits
  assign adv_o = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      s1_valid_q  <= issue_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Stage 1 waits on the table read, stage 2 multiplies, stage 3 rounds
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_last_q   <= issue_i.last;
      s1_sym_i_q  <= issue_i.sym_i;
      s1_sym_q_q  <= issue_i.sym_q;
      s2_last_q   <= s1_last_q;
      s2_prod_i_q <= s1_sym_i_q * chip_i;
      s2_prod_q_q <= s1_sym_q_q * chip_i;
      out_last_q  <= s2_last_q;
      out_i_q     <= round_sat(s2_prod_i_q);
      out_q_q     <= round_sat(s2_prod_q_q);
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.out_i     = out_i_q;
  assign result_o.out_q     = out_q_q;
  assign result_o.last_chip = out_last_q;

endmodule
